>>> rtl/tkn_pkg.sv
// shared types, token kind codes, keyword table and byte classes for the source tokenizer
package tkn_pkg;

    localparam int MAX_KEYWORD_LEN_DEF = 8;
    localparam int POS_BITS_DEF        = 16;
    localparam int LEN_W               = 16;
    localparam int OFF_W               = 16;
    localparam int KIND_W              = 6;
    localparam int KW_NUM              = 26;
    localparam int KW_MAX_LEN          = 8;
    localparam int RUN_MAX             = 3;
    localparam int RUN_CNT_W           = 2;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_IDENT   = 6'd0;
    localparam t_kind KIND_INT     = 6'd1;
    localparam t_kind KIND_STRING  = 6'd2;
    localparam t_kind KIND_LPAREN  = 6'd3;
    localparam t_kind KIND_RPAREN  = 6'd4;
    localparam t_kind KIND_LBRACE  = 6'd5;
    localparam t_kind KIND_RBRACE  = 6'd6;
    localparam t_kind KIND_LBRACK  = 6'd7;
    localparam t_kind KIND_RBRACK  = 6'd8;
    localparam t_kind KIND_SEMI    = 6'd9;
    localparam t_kind KIND_COMMA   = 6'd10;
    localparam t_kind KIND_DOT     = 6'd11;
    localparam t_kind KIND_AT      = 6'd12;
    localparam t_kind KIND_EQUAL   = 6'd13;
    localparam t_kind KIND_EQEQ    = 6'd14;
    localparam t_kind KIND_PLUS    = 6'd15;
    localparam t_kind KIND_MINUS   = 6'd16;
    localparam t_kind KIND_STAR    = 6'd17;
    localparam t_kind KIND_SLASH   = 6'd18;
    localparam t_kind KIND_GT      = 6'd19;
    localparam t_kind KIND_GE      = 6'd20;
    localparam t_kind KIND_KW_BASE = 6'd21;
    localparam t_kind KIND_END     = 6'd47;
    localparam t_kind KIND_UNTERM  = 6'd48;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_STR,
        MODE_EQ,
        MODE_GT
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } t_token;

    // tokens produced by one source byte, first in slot 0
    typedef struct packed {
        logic [RUN_CNT_W-1:0]    cnt;
        t_token [RUN_MAX-1:0]    tok;
    } t_run;

    // keyword text, right-justified, first character in the highest used byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TXT [KW_NUM] = '{
        "if", "elif", "else", "return", "for", "while", "break", "continue",
        "struct", "enum", "true", "false", "const", "alloc", "free", "cast",
        "sizeof", "defer", "switch", "in", "int", "char", "float", "double",
        "long", "bool"
    };

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd2, 4'd4, 4'd4, 4'd6, 4'd3, 4'd5, 4'd5, 4'd8,
        4'd6, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd4, 4'd4,
        4'd6, 4'd5, 4'd6, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
        4'd4, 4'd4
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {"(", ")", "{", "}", "[", "]", ";", ",", ".", "@",
                         "+", "-", "*", "/"};
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "[":     k = KIND_LBRACK;
            "]":     k = KIND_RBRACK;
            ";":     k = KIND_SEMI;
            ",":     k = KIND_COMMA;
            ".":     k = KIND_DOT;
            "@":     k = KIND_AT;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/tkn_if.sv
// byte and token handshake channels of the source tokenizer
interface tkn_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_source;

    modport source (output valid, source_byte, end_of_source, input ready);
    modport sink   (input valid, source_byte, end_of_source, output ready);
endinterface

interface tkn_token_if;
    logic                        valid;
    logic                        ready;
    logic [tkn_pkg::KIND_W-1:0]  token_kind;
    logic [tkn_pkg::OFF_W-1:0]   token_offset;
    logic [tkn_pkg::LEN_W-1:0]   token_length;
    logic                        last_of_run;

    modport source (output valid, token_kind, token_offset, token_length, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, token_offset, token_length, last_of_run,
                    output ready);
endinterface

>>> rtl/tkn_kw_match.sv
// keyword lookup over the first bytes of the current word
module tkn_kw_match (
    input  logic [tkn_pkg::KW_MAX_LEN-1:0][7:0] i_word,
    input  logic [tkn_pkg::LEN_W-1:0]           i_len,
    output tkn_pkg::t_kind                      o_kind
);

    localparam int LW  = tkn_pkg::LEN_W;
    localparam int KWL = tkn_pkg::KW_MAX_LEN;

    always_comb begin
        int   idx;
        logic same;
        o_kind = tkn_pkg::KIND_IDENT;
        for (int k = 0; k < tkn_pkg::KW_NUM; k++) begin
            same = (i_len == LW'(tkn_pkg::KW_LEN[k]));
            for (int i = 0; i < KWL; i++) begin
                idx = (int'(tkn_pkg::KW_LEN[k]) - 1 - i) & (KWL - 1);
                if (i < int'(tkn_pkg::KW_LEN[k]) &&
                    i_word[i] != tkn_pkg::KW_TXT[k][8*idx +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                o_kind = tkn_pkg::t_kind'(int'(tkn_pkg::KIND_KW_BASE) + k);
            end
        end
    end

endmodule

>>> rtl/tkn_scan.sv
// scan state, word buffer and per-byte token generation
module tkn_scan #(
    parameter int MAX_KEYWORD_LEN = tkn_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int POS_BITS        = tkn_pkg::POS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output tkn_pkg::t_run o_run
);

    localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);
    localparam int LW    = tkn_pkg::LEN_W;
    localparam int OW    = tkn_pkg::OFF_W;
    localparam int KWL   = tkn_pkg::KW_MAX_LEN;
    localparam int CW    = tkn_pkg::RUN_CNT_W;

    tkn_pkg::t_mode        r_mode, n_mode, s_mode;
    logic [POS_BITS-1:0]   r_start, n_start, s_start;
    logic [LW-1:0]         r_len, n_len, s_len;
    logic [POS_BITS-1:0]   r_pos, n_pos, pos1;
    logic [7:0]            r_word [MAX_KEYWORD_LEN];
    logic [7:0]            n_word [MAX_KEYWORD_LEN];

    logic c_alpha, c_digit, c_space, c_wchar, c_punct, c_eq, c_gt, c_quote;
    tkn_pkg::t_kind c_pk;
    logic brk, close_tok, done, fresh;
    logic w_start, w_cont, w_en;
    logic [IDX_W-1:0] w_idx;
    logic [LW-1:0] len_inc, kw_len;
    logic [KWL-1:0][7:0] kw_word;
    tkn_pkg::t_kind kw_kind;

    function automatic tkn_pkg::t_token make_tok(input tkn_pkg::t_kind k,
                                                 input logic [POS_BITS-1:0] off,
                                                 input logic [LW-1:0] len);
        tkn_pkg::t_token t;
        t.kind   = k;
        t.offset = OW'(off);
        t.length = len;
        return t;
    endfunction

    // token left behind by a word, number, string or operator still open
    function automatic tkn_pkg::t_token pend_tok(input tkn_pkg::t_mode m,
                                                 input logic [POS_BITS-1:0] st,
                                                 input logic [LW-1:0] len,
                                                 input tkn_pkg::t_kind kw);
        tkn_pkg::t_token t;
        case (m)
            tkn_pkg::MODE_WORD: t = make_tok(kw, st, len);
            tkn_pkg::MODE_NUM:  t = make_tok(tkn_pkg::KIND_INT, st, len);
            tkn_pkg::MODE_STR:  t = make_tok(tkn_pkg::KIND_UNTERM, st, len);
            tkn_pkg::MODE_EQ:   t = make_tok(tkn_pkg::KIND_EQUAL, st, LW'(1));
            tkn_pkg::MODE_GT:   t = make_tok(tkn_pkg::KIND_GT, st, LW'(1));
            default:            t = make_tok(tkn_pkg::KIND_IDENT, st, len);
        endcase
        return t;
    endfunction

    // byte classes
    always_comb begin
        c_alpha = tkn_pkg::is_alpha(i_byte);
        c_digit = tkn_pkg::is_digit(i_byte);
        c_space = tkn_pkg::is_space(i_byte);
        c_wchar = tkn_pkg::is_word_char(i_byte);
        c_punct = tkn_pkg::is_punct(i_byte);
        c_pk    = tkn_pkg::punct_kind(i_byte);
        c_eq    = (i_byte == "=");
        c_gt    = (i_byte == ">");
        c_quote = (i_byte == "\"");
    end

    always_comb begin
        brk = ((r_mode == tkn_pkg::MODE_WORD) && !c_wchar) ||
              ((r_mode == tkn_pkg::MODE_NUM) && !c_digit) ||
              ((r_mode == tkn_pkg::MODE_EQ || r_mode == tkn_pkg::MODE_GT) && !c_eq);
        close_tok = ((r_mode == tkn_pkg::MODE_STR) && c_quote) ||
                    ((r_mode == tkn_pkg::MODE_EQ || r_mode == tkn_pkg::MODE_GT) && c_eq);
        done = ((r_mode == tkn_pkg::MODE_WORD) && c_wchar) ||
               ((r_mode == tkn_pkg::MODE_NUM) && c_digit) ||
               (r_mode == tkn_pkg::MODE_STR) ||
               ((r_mode == tkn_pkg::MODE_EQ || r_mode == tkn_pkg::MODE_GT) && c_eq);
        fresh   = !done && !c_space;
        pos1    = r_pos + 1'b1;
        len_inc = (r_len == '1) ? r_len : r_len + 1'b1;
    end

    // word buffer write and the word that a flush in this cycle would see
    always_comb begin
        w_start = c_alpha && (r_mode != tkn_pkg::MODE_WORD) && (r_mode != tkn_pkg::MODE_STR);
        w_cont  = (r_mode == tkn_pkg::MODE_WORD) && c_wchar;
        w_en    = w_start || (w_cont && (r_len < LW'(MAX_KEYWORD_LEN)));
        w_idx   = w_start ? '0 : r_len[IDX_W-1:0];
        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            n_word[i] = (w_en && (w_idx == IDX_W'(i))) ? i_byte : r_word[i];
        end
        for (int i = 0; i < KWL; i++) begin
            kw_word[i] = n_word[i];
        end
        if ((r_mode == tkn_pkg::MODE_WORD) && !c_wchar) begin
            kw_len = r_len;
        end else if (w_start) begin
            kw_len = LW'(1);
        end else begin
            kw_len = len_inc;
        end
    end

    tkn_kw_match u_kw_match (
        .i_word (kw_word),
        .i_len  (kw_len),
        .o_kind (kw_kind)
    );

    // next state
    always_comb begin
        s_mode  = r_mode;
        s_start = r_start;
        s_len   = r_len;
        case (r_mode)
            tkn_pkg::MODE_WORD: begin
                if (c_wchar) begin
                    s_len = len_inc;
                end else begin
                    s_mode = tkn_pkg::MODE_IDLE;
                end
            end
            tkn_pkg::MODE_NUM: begin
                if (c_digit) begin
                    s_len = len_inc;
                end else begin
                    s_mode = tkn_pkg::MODE_IDLE;
                end
            end
            tkn_pkg::MODE_STR: begin
                if (c_quote) begin
                    s_mode = tkn_pkg::MODE_IDLE;
                end else begin
                    s_len = len_inc;
                end
            end
            default: s_mode = tkn_pkg::MODE_IDLE;
        endcase

        if (fresh && !c_punct) begin
            if (c_eq || c_gt) begin
                s_mode  = c_eq ? tkn_pkg::MODE_EQ : tkn_pkg::MODE_GT;
                s_start = r_pos;
                s_len   = LW'(1);
            end else if (c_quote) begin
                s_mode  = tkn_pkg::MODE_STR;
                s_start = pos1;
                s_len   = '0;
            end else if (c_alpha) begin
                s_mode  = tkn_pkg::MODE_WORD;
                s_start = r_pos;
                s_len   = LW'(1);
            end else if (c_digit) begin
                s_mode  = tkn_pkg::MODE_NUM;
                s_start = r_pos;
                s_len   = LW'(1);
            end
        end

        if (i_last) begin
            n_mode  = tkn_pkg::MODE_IDLE;
            n_start = '0;
            n_len   = '0;
            n_pos   = '0;
        end else begin
            n_mode  = s_mode;
            n_start = s_start;
            n_len   = s_len;
            n_pos   = pos1;
        end
    end

    // tokens of this byte, in emission order
    always_comb begin
        logic [CW-1:0] cnt;
        cnt       = '0;
        o_run.tok = '0;
        if (brk) begin
            o_run.tok[cnt] = pend_tok(r_mode, r_start, r_len, kw_kind);
            cnt = cnt + 1'b1;
        end
        if (close_tok) begin
            if (r_mode == tkn_pkg::MODE_STR) begin
                o_run.tok[cnt] = make_tok(tkn_pkg::KIND_STRING, r_start, r_len);
            end else begin
                o_run.tok[cnt] = make_tok((r_mode == tkn_pkg::MODE_EQ) ?
                                          tkn_pkg::KIND_EQEQ : tkn_pkg::KIND_GE,
                                          r_start, LW'(2));
            end
            cnt = cnt + 1'b1;
        end
        if (fresh && c_punct) begin
            o_run.tok[cnt] = make_tok(c_pk, r_pos, LW'(1));
            cnt = cnt + 1'b1;
        end
        if (i_last) begin
            if (s_mode != tkn_pkg::MODE_IDLE) begin
                o_run.tok[cnt] = pend_tok(s_mode, s_start, s_len, kw_kind);
                cnt = cnt + 1'b1;
            end
            o_run.tok[cnt] = make_tok(tkn_pkg::KIND_END, pos1, '0);
            cnt = cnt + 1'b1;
        end
        o_run.cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tkn_pkg::MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_word <= n_word;
        end
    end

endmodule

>>> rtl/tkn_out_buf.sv
// result register holding the tokens of one byte and draining them one per transaction
module tkn_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tkn_pkg::t_run       i_run,
    output logic                o_free,
    tkn_token_if.source         o_tok
);

    localparam int CW = tkn_pkg::RUN_CNT_W;

    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_head;
    tkn_pkg::t_token  r_tok [tkn_pkg::RUN_MAX];
    tkn_pkg::t_token  cur;
    logic             fire;

    assign cur                = r_tok[r_head];
    assign o_tok.valid        = (r_cnt != '0);
    assign o_tok.token_kind   = cur.kind;
    assign o_tok.token_offset = cur.offset;
    assign o_tok.token_length = cur.length;
    assign o_tok.last_of_run  = (r_cnt == CW'(1));
    assign fire               = o_tok.valid && o_tok.ready;

    // empty now, or the last token leaves in this cycle
    assign o_free = (r_cnt == '0) || ((r_cnt == CW'(1)) && o_tok.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= '0;
        end else if (i_load) begin
            r_cnt  <= i_run.cnt;
            r_head <= '0;
        end else if (fire) begin
            r_cnt  <= r_cnt - 1'b1;
            r_head <= r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < tkn_pkg::RUN_MAX; i++) begin
                r_tok[i] <= i_run.tok[i];
            end
        end
    end

endmodule

>>> rtl/source_tokenizer.sv
// source tokenizer top level: input register, scanner and token result register
//
// i_src carries one source byte per transaction, with end_of_source on the
// final byte of a text. o_tok carries tokens as kind, start offset and length;
// last_of_run marks the final token that one byte produced.
// A byte is taken into the input register; once the result register is
// free, the scanner updates its state and loads the tokens of that byte
// into the result register, which then offers the first of them. A byte
// yields zero to three tokens, and the result register sends them one per
// cycle while the receiver is ready, so one byte is taken per cycle while
// no byte makes more than one token and the receiver does not stall. The
// scanner waits only while the result register still holds tokens the
// receiver has not taken, and i_src stays ready as long as the input
// register can move on. When the receiver stalls, the current token holds
// and at most one more byte waits in the input register. Reset empties both
// registers and returns the scanner to idle at position zero; the keyword
// buffer is not cleared. An end token follows every end_of_source byte,
// after which positions restart at zero for the next text.
module source_tokenizer #(
    parameter int MAX_KEYWORD_LEN = tkn_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int POS_BITS        = tkn_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkn_byte_if.sink    i_src,
    tkn_token_if.source o_tok
);

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    logic          w_free;
    logic          w_consume;
    tkn_pkg::t_run w_run;

    assign w_consume   = r_in_valid && w_free;
    assign i_src.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_src.ready) begin
            r_in_valid <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_in_byte <= i_src.source_byte;
            r_in_last <= i_src.end_of_source;
        end
    end

    tkn_scan #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .POS_BITS        (POS_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_consume),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_run   (w_run)
    );

    tkn_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_consume),
        .i_run   (w_run),
        .o_free  (w_free),
        .o_tok   (o_tok)
    );

endmodule
